[src/pwmp_pkg.sv]
`timescale 1ns / 1ps

package pwmp_pkg;

	// Bitmap sizing
	localparam int unsigned MAX_PIECES   = 32768;
	localparam int unsigned BITMAP_BYTES = (MAX_PIECES + 7) / 8;
	localparam int unsigned BM_AW        = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	localparam int unsigned BOUND_W      = $clog2(MAX_PIECES + 1);

	// Front-to-back queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [15:0] NUM_PIECES_RST = 16'd32768;

	// Payload layout
	localparam int unsigned FIELD_BYTES  = 4;
	localparam logic [31:0] HAVE_PAYLOAD = 32'(FIELD_BYTES);
	localparam logic [31:0] REQ_PAYLOAD  = 32'(3 * FIELD_BYTES);

	// Message ids on the wire
	localparam logic [7:0] ID_CHOKE      = 8'd0;
	localparam logic [7:0] ID_UNCHOKE    = 8'd1;
	localparam logic [7:0] ID_INTERESTED = 8'd2;
	localparam logic [7:0] ID_NOT_INT    = 8'd3;
	localparam logic [7:0] ID_HAVE       = 8'd4;
	localparam logic [7:0] ID_BITFIELD   = 8'd5;
	localparam logic [7:0] ID_REQUEST    = 8'd6;
	localparam logic [7:0] ID_PIECE      = 8'd7;
	localparam logic [7:0] ID_CANCEL     = 8'd8;

	// Reported message kinds
	localparam logic [3:0] KIND_CHOKE      = 4'd0;
	localparam logic [3:0] KIND_UNCHOKE    = 4'd1;
	localparam logic [3:0] KIND_INTERESTED = 4'd2;
	localparam logic [3:0] KIND_NOT_INT    = 4'd3;
	localparam logic [3:0] KIND_HAVE       = 4'd4;
	localparam logic [3:0] KIND_BITFIELD   = 4'd5;
	localparam logic [3:0] KIND_REQUEST    = 4'd6;
	localparam logic [3:0] KIND_KEEPALIVE  = 4'd9;
	localparam logic [3:0] KIND_UNKNOWN    = 4'd10;

	// Result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// One queue entry: an optional bitmap byte write (bitfield payload),
	// an optional result, and for an accepted have a bit-set on the bitmap.
	typedef struct packed {
		logic             wr;
		logic             res;
		logic             set;
		logic [BM_AW-1:0] addr;
		logic [7:0]       data;
		logic [3:0]       kind;
		logic [1:0]       status;
		logic [31:0]      idx;
		logic [31:0]      beg;
		logic [31:0]      len;
	} cmd_t;

endpackage

[src/pwmp_front.sv]
`timescale 1ns / 1ps

module pwmp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	output logic                  push,
	output pwmp_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		PH_LEN     = 3'b001,
		PH_ID      = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	phase_t      phase_q, ph_nx;
	logic [1:0]  len_cnt_q, lc_nx;
	logic [31:0] msg_len_q, ml_nx;
	logic [7:0]  msg_id_q, id_nx;
	logic [31:0] pos_q, pos_nx;
	logic [31:0] fa_q, fb_q, fc_q, fa_nx, fb_nx, fc_nx;
	logic        ovf_q, ovf_nx;
	logic [15:0] num_pieces_q;

	logic [pwmp_pkg::BOUND_W-1:0] bound, cap;
	logic [31:0] payload;
	logic        fin;
	logic [7:0]  fin_id;

	// effective piece bound and bitmap byte capacity
	always_comb begin
		if (32'(num_pieces_q) > 32'(pwmp_pkg::MAX_PIECES))
			bound = pwmp_pkg::BOUND_W'(pwmp_pkg::MAX_PIECES);
		else
			bound = pwmp_pkg::BOUND_W'(num_pieces_q);
		cap = pwmp_pkg::BOUND_W'((33'(bound) + 33'd7) >> 3);
	end

	assign payload = msg_len_q - 32'd1;

	// deframer
	always_comb begin
		ph_nx  = phase_q;
		lc_nx  = len_cnt_q;
		ml_nx  = msg_len_q;
		id_nx  = msg_id_q;
		pos_nx = pos_q;
		fa_nx  = fa_q;
		fb_nx  = fb_q;
		fc_nx  = fc_q;
		ovf_nx = ovf_q;
		fin    = 1'b0;
		fin_id = msg_id_q;
		cmd    = '0;

		unique case (phase_q)
			PH_LEN: begin
				ml_nx = {msg_len_q[23:0], data_byte};
				if (len_cnt_q == 2'd3) begin
					lc_nx = 2'd0;
					if (ml_nx == 32'd0) begin
						cmd.res    = 1'b1;
						cmd.kind   = pwmp_pkg::KIND_KEEPALIVE;
						cmd.status = pwmp_pkg::ST_OK;
					end else begin
						ph_nx = PH_ID;
					end
				end else begin
					lc_nx = len_cnt_q + 2'd1;
				end
			end
			PH_ID: begin
				id_nx  = data_byte;
				fin_id = data_byte;
				fa_nx  = '0;
				fb_nx  = '0;
				fc_nx  = '0;
				ovf_nx = 1'b0;
				pos_nx = '0;
				if (msg_len_q == 32'd1) begin
					fin   = 1'b1;
					ph_nx = PH_LEN;
				end else begin
					ph_nx = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (msg_id_q == pwmp_pkg::ID_HAVE || msg_id_q == pwmp_pkg::ID_REQUEST) begin
					if (pos_q < 32'(pwmp_pkg::FIELD_BYTES))
						fa_nx = {fa_q[23:0], data_byte};
					else if (pos_q < 32'(2 * pwmp_pkg::FIELD_BYTES))
						fb_nx = {fb_q[23:0], data_byte};
					else if (pos_q < 32'(3 * pwmp_pkg::FIELD_BYTES))
						fc_nx = {fc_q[23:0], data_byte};
				end else if (msg_id_q == pwmp_pkg::ID_BITFIELD) begin
					if (pos_q < 32'(cap) && pos_q < 32'(pwmp_pkg::BITMAP_BYTES)) begin
						cmd.wr   = 1'b1;
						cmd.addr = pos_q[pwmp_pkg::BM_AW-1:0];
						cmd.data = data_byte;
					end else begin
						ovf_nx = 1'b1;
					end
				end
				pos_nx = pos_q + 32'd1;
				if (pos_q + 32'd2 == msg_len_q) begin
					fin   = 1'b1;
					ph_nx = PH_LEN;
				end
			end
			default: begin
				ph_nx = PH_LEN;
			end
		endcase

		// classify the finished message
		if (fin) begin
			cmd.res    = 1'b1;
			cmd.kind   = 4'(fin_id);
			cmd.status = pwmp_pkg::ST_OK;
			unique case (fin_id) inside
				pwmp_pkg::ID_HAVE: begin
					if (payload < pwmp_pkg::HAVE_PAYLOAD) begin
						cmd.status = pwmp_pkg::ST_SHORT;
					end else begin
						cmd.idx = fa_nx;
						if (fa_nx >= 32'(bound)) begin
							cmd.status = pwmp_pkg::ST_RANGE;
						end else begin
							cmd.set  = 1'b1;
							cmd.addr = fa_nx[pwmp_pkg::BM_AW+2:3];
							cmd.data = 8'h80 >> fa_nx[2:0];
						end
					end
				end
				pwmp_pkg::ID_BITFIELD: begin
					if (ovf_nx)
						cmd.status = pwmp_pkg::ST_OVERFLOW;
				end
				pwmp_pkg::ID_REQUEST: begin
					if (payload < pwmp_pkg::REQ_PAYLOAD) begin
						cmd.status = pwmp_pkg::ST_SHORT;
					end else begin
						cmd.idx = fa_nx;
						cmd.beg = fb_nx;
						cmd.len = fc_nx;
						if (fa_nx >= 32'(bound))
							cmd.status = pwmp_pkg::ST_RANGE;
					end
				end
				pwmp_pkg::ID_CHOKE, pwmp_pkg::ID_UNCHOKE, pwmp_pkg::ID_INTERESTED,
				pwmp_pkg::ID_NOT_INT, pwmp_pkg::ID_PIECE, pwmp_pkg::ID_CANCEL: begin
				end
				default: begin
					cmd.kind = pwmp_pkg::KIND_UNKNOWN;
				end
			endcase
		end
	end

	assign push = accept && (cmd.wr || cmd.res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEN;
			len_cnt_q    <= '0;
			msg_len_q    <= '0;
			msg_id_q     <= '0;
			pos_q        <= '0;
			fa_q         <= '0;
			fb_q         <= '0;
			fc_q         <= '0;
			ovf_q        <= 1'b0;
			num_pieces_q <= pwmp_pkg::NUM_PIECES_RST;
		end else begin
			if (cfg_we)
				num_pieces_q <= cfg_wdata;
			if (accept) begin
				phase_q   <= ph_nx;
				len_cnt_q <= lc_nx;
				msg_len_q <= ml_nx;
				msg_id_q  <= id_nx;
				pos_q     <= pos_nx;
				fa_q      <= fa_nx;
				fb_q      <= fb_nx;
				fc_q      <= fc_nx;
				ovf_q     <= ovf_nx;
			end
		end
	end

endmodule

[src/pwmp_fifo.sv]
`timescale 1ns / 1ps

module pwmp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pwmp_pkg::cmd_t push_data,
	input  logic           pop,
	output pwmp_pkg::cmd_t pop_data,
	output logic           full,
	output logic           empty
);

	pwmp_pkg::cmd_t                 entry_q [pwmp_pkg::FIFO_DEPTH];
	logic [pwmp_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [pwmp_pkg::FIFO_AW:0]     count_q;

	localparam logic [pwmp_pkg::FIFO_AW-1:0] LAST = pwmp_pkg::FIFO_AW'(pwmp_pkg::FIFO_DEPTH - 1);
	localparam logic [pwmp_pkg::FIFO_AW:0]   DEPTH_C = (pwmp_pkg::FIFO_AW + 1)'(pwmp_pkg::FIFO_DEPTH);

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[src/pwmp_back.sv]
`timescale 1ns / 1ps

module pwmp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  pwmp_pkg::cmd_t cmd,
	output logic           pop,
	output logic           running,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     msg_kind,
	output logic [1:0]     status,
	output logic           peer_choking_now,
	output logic           peer_interested_now,
	output logic [31:0]    piece_idx,
	output logic [31:0]    block_begin,
	output logic [31:0]    block_length
);

	typedef enum logic [2:0] {
		BK_CLEAR = 3'b001,
		BK_RUN   = 3'b010,
		BK_RMW   = 3'b100
	} bk_state_t;

	localparam logic [pwmp_pkg::BM_AW-1:0] LAST_ADDR =
		pwmp_pkg::BM_AW'(pwmp_pkg::BITMAP_BYTES - 1);

	bk_state_t state_q, state_nx;
	logic [pwmp_pkg::BM_AW-1:0] clr_addr_q;
	logic [pwmp_pkg::BM_AW-1:0] rmw_addr_q;
	logic [7:0]                 rmw_mask_q;
	logic [7:0]                 rd_q;
	logic [7:0]                 bitmap [pwmp_pkg::BITMAP_BYTES];

	logic                       mem_we, mem_re;
	logic [pwmp_pkg::BM_AW-1:0] mem_waddr;
	logic [7:0]                 mem_wdata;

	logic choking_q, interested_q, choking_nx, interested_nx;
	logic out_valid_q;

	assign running = (state_q != BK_CLEAR);
	assign pop = (state_q == BK_RUN) && cmd_valid && (!cmd.res || !out_valid_q || out_ready);
	assign mem_re = pop && cmd.set;

	always_comb begin
		state_nx  = state_q;
		mem_we    = 1'b0;
		mem_waddr = cmd.addr;
		mem_wdata = cmd.data;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == LAST_ADDR)
					state_nx = BK_RUN;
			end
			BK_RUN: begin
				mem_we = pop && cmd.wr;
				if (pop && cmd.set)
					state_nx = BK_RMW;
			end
			BK_RMW: begin
				mem_we    = 1'b1;
				mem_waddr = rmw_addr_q;
				mem_wdata = rd_q | rmw_mask_q;
				state_nx  = BK_RUN;
			end
			default: begin
				state_nx = BK_CLEAR;
			end
		endcase
	end

	// peer flags after this message
	always_comb begin
		choking_nx    = choking_q;
		interested_nx = interested_q;
		if (pop && cmd.res) begin
			unique case (cmd.kind)
				pwmp_pkg::KIND_CHOKE:      choking_nx    = 1'b1;
				pwmp_pkg::KIND_UNCHOKE:    choking_nx    = 1'b0;
				pwmp_pkg::KIND_INTERESTED: interested_nx = 1'b1;
				pwmp_pkg::KIND_NOT_INT:    interested_nx = 1'b0;
				default: begin
				end
			endcase
		end
	end

	// peer bitmap
	always_ff @(posedge clk) begin
		if (mem_we)
			bitmap[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= bitmap[cmd.addr];
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rmw_addr_q <= cmd.addr;
			rmw_mask_q <= cmd.data;
		end
		if (pop && cmd.res) begin
			msg_kind            <= cmd.kind;
			status              <= cmd.status;
			peer_choking_now    <= choking_nx;
			peer_interested_now <= interested_nx;
			piece_idx           <= cmd.idx;
			block_begin         <= cmd.beg;
			block_length        <= cmd.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_CLEAR;
			clr_addr_q   <= '0;
			choking_q    <= 1'b1;
			interested_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_nx;
			choking_q    <= choking_nx;
			interested_q <= interested_nx;
			if (state_q == BK_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (pop && cmd.res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/peer_wire_message_parser_top.sv]
`timescale 1ns / 1ps
// Peer-wire message parser: deframes length-prefixed peer messages from a
// received byte stream and reports one result transaction per message.
// Input channel: data_byte with in_valid/in_ready, one byte per transaction.
// Output channel: msg_kind, status, flags and the request/have fields with
// out_valid/out_ready, one transaction per completed message (keep-alive too).
// Config: cfg_we/cfg_wdata write num_pieces; write it only while idle.
// Throughput: one byte per cycle sustained while in_ready is high. A have
// message makes the back end do a bitmap read-modify-write before its next pop,
// absorbed by the 4-entry command queue since a have spans at least nine bytes.
// Result path: the message's last byte is written into the queue, then the
// result register is loaded and out_valid rises; a back end busy with a have or
// a result still held for out_ready can delay the second step.
// Reset: flags go to choking / not interested; the 4096-byte peer bitmap is
// then cleared one byte per cycle, with in_ready low.
// Output stall: the result register holds while out_ready is low; the queue
// keeps filling and in_ready drops only when it is full.
module peer_wire_message_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  msg_kind,
	output logic [1:0]  status,
	output logic        peer_choking_now,
	output logic        peer_interested_now,
	output logic [31:0] piece_idx,
	output logic [31:0] block_begin,
	output logic [31:0] block_length
);

	pwmp_pkg::cmd_t front_cmd, back_cmd;
	logic push, pop, q_full, q_empty, running, accept;

	// front takes a byte whenever the bitmap is cleared and the queue has room
	assign in_ready = running && !q_full;
	assign accept   = in_valid && in_ready;

	pwmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.cmd       (front_cmd)
	);

	pwmp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.pop       (pop),
		.pop_data  (back_cmd),
		.full      (q_full),
		.empty     (q_empty)
	);

	pwmp_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (!q_empty),
		.cmd                 (back_cmd),
		.pop                 (pop),
		.running             (running),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.msg_kind            (msg_kind),
		.status              (status),
		.peer_choking_now    (peer_choking_now),
		.peer_interested_now (peer_interested_now),
		.piece_idx           (piece_idx),
		.block_begin         (block_begin),
		.block_length        (block_length)
	);

endmodule

[src/pwmp_checker.sv]
`timescale 1ns / 1ps

module pwmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  msg_kind,
	input logic [1:0]  status,
	input logic        peer_choking_now,
	input logic        peer_interested_now,
	input logic [31:0] piece_idx,
	input logic [31:0] block_begin,
	input logic [31:0] block_length
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(msg_kind) && $stable(status)
			&& $stable(piece_idx) && $stable(block_begin) && $stable(block_length))
		else $error("result changed while stalled");

	// only have and request carry fields
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_kind != pwmp_pkg::KIND_HAVE && msg_kind != pwmp_pkg::KIND_REQUEST
			|-> piece_idx == '0 && block_begin == '0 && block_length == '0)
		else $error("fields set on a message that has none");

	// flag messages are reflected in the same result
	a_choke_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (msg_kind == pwmp_pkg::KIND_CHOKE || msg_kind == pwmp_pkg::KIND_UNCHOKE)
			|-> peer_choking_now == (msg_kind == pwmp_pkg::KIND_CHOKE))
		else $error("choking flag does not follow choke/unchoke");

	a_int_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (msg_kind == pwmp_pkg::KIND_INTERESTED
			|| msg_kind == pwmp_pkg::KIND_NOT_INT)
			|-> peer_interested_now == (msg_kind == pwmp_pkg::KIND_INTERESTED))
		else $error("interested flag does not follow interested/not-interested");

	// overflow only from bitfield
	a_overflow_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pwmp_pkg::ST_OVERFLOW |-> msg_kind == pwmp_pkg::KIND_BITFIELD)
		else $error("overflow status on a non-bitfield message");

endmodule

bind peer_wire_message_parser_top pwmp_checker u_pwmp_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	// Bytes go in on a valid/ready channel, one byte per transaction. Every byte
	// that completes a message (or a keep-alive length prefix) leaves exactly one
	// result transaction on the output channel. A scoreboard queue holds the
	// results still owed by the DUT, oldest first.

	localparam int PHASE_BYTES  = 245;        // six random phases, at least 1470 bytes in all
	localparam int QUIET_CYCLES = 8;          // settle time before a num_pieces write
	localparam int DRAIN_CYCLES = 20;         // watch for stray results at the end
	localparam int TIMEOUT_NS   = 10_000_000; // watchdog limit, far above the slowest run

	// One result transaction, field for field as it leaves the DUT.
	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  stat;
		logic        choking;
		logic        interested;
		logic [31:0] idx;
		logic [31:0] beg;
		logic [31:0] len;
	} msg_result_t;

	// Directed script row: either a num_pieces write or one whole message.
	// For a message, mlen == 0 is a keep-alive; the payload is taken MSB first.
	typedef struct packed {
		logic        is_cfg;
		logic [15:0] cfg_val;
		logic [31:0] mlen;
		logic [7:0]  id;
		logic [127:0] pay;
		logic        typed;
		msg_result_t want;
	} script_row_t;

	typedef enum logic [1:0] {PS_LEN, PS_ID, PS_BODY} frame_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  msg_kind;
	logic [1:0]  status;
	logic        peer_choking_now;
	logic        peer_interested_now;
	logic [31:0] piece_idx;
	logic [31:0] block_begin;
	logic [31:0] block_length;

	peer_wire_message_parser_top u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.msg_kind            (msg_kind),
		.status              (status),
		.peer_choking_now    (peer_choking_now),
		.peer_interested_now (peer_interested_now),
		.piece_idx           (piece_idx),
		.block_begin         (block_begin),
		.block_length        (block_length)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser shadow state. Reset values double as the declaration values,
	// since reset is applied exactly once at time zero.
	// The peer bitmap itself never shows on any output, so only the
	// overflow flag of a bitfield message is tracked here.
	// ------------------------------------------------------------------
	frame_phase_t pw_phase      = PS_LEN;
	logic [31:0]  pw_count      = '0;
	logic [31:0]  pw_len        = '0;
	logic [7:0]   pw_id         = '0;
	logic [31:0]  pw_fa         = '0;
	logic [31:0]  pw_fb         = '0;
	logic [31:0]  pw_fc         = '0;
	logic         pw_ovf        = 1'b0;
	logic         pw_choking    = 1'b1;
	logic         pw_interested = 1'b0;
	logic [15:0]  pw_num_pieces = pwmp_pkg::NUM_PIECES_RST;

	msg_result_t  owed_q[$];      // results the DUT still has to deliver
	logic [7:0]   body_q[$];      // payload of the message being assembled
	script_row_t  script[$];
	logic         typed_pending = 1'b0;
	msg_result_t  typed_want;
	int unsigned  tx_idle_pct = 18;
	int unsigned  rx_idle_pct = 78;
	int unsigned  bytes_sent = 0;
	int           err_cnt = 0;

	function automatic msg_result_t result_of(input logic [3:0] kind, input logic [1:0] stat,
			input logic ch, input logic it, input logic [31:0] idx, input logic [31:0] beg,
			input logic [31:0] len);
		msg_result_t r;
		r.kind = kind;
		r.stat = stat;
		r.choking = ch;
		r.interested = it;
		r.idx = idx;
		r.beg = beg;
		r.len = len;
		return r;
	endfunction

	// Effective bound: the register, clamped to what the bitmap can hold.
	function automatic logic [31:0] piece_limit();
		return (32'(pw_num_pieces) > 32'(pwmp_pkg::MAX_PIECES)) ?
			32'(pwmp_pkg::MAX_PIECES) : 32'(pw_num_pieces);
	endfunction

	// Dispatch of a completed message: flags, status and reported fields.
	task automatic close_msg(output msg_result_t res);
		logic [31:0] payload;
		logic [31:0] bnd;
		logic [3:0]  kind;
		logic [1:0]  st;
		logic [31:0] idx;
		logic [31:0] beg;
		logic [31:0] len;
		payload = pw_len - 32'd1;
		bnd = piece_limit();
		kind = pw_id[3:0];
		st = pwmp_pkg::ST_OK;
		idx = '0;
		beg = '0;
		len = '0;
		case (pw_id)
		pwmp_pkg::ID_CHOKE:      pw_choking = 1'b1;
		pwmp_pkg::ID_UNCHOKE:    pw_choking = 1'b0;
		pwmp_pkg::ID_INTERESTED: pw_interested = 1'b1;
		pwmp_pkg::ID_NOT_INT:    pw_interested = 1'b0;
		pwmp_pkg::ID_HAVE: begin
			if (payload < pwmp_pkg::HAVE_PAYLOAD) begin
				st = pwmp_pkg::ST_SHORT;
			end else begin
				idx = pw_fa;
				if (idx >= bnd)
					st = pwmp_pkg::ST_RANGE;
			end
		end
		pwmp_pkg::ID_BITFIELD: begin
			if (pw_ovf)
				st = pwmp_pkg::ST_OVERFLOW;
		end
		pwmp_pkg::ID_REQUEST: begin
			if (payload < pwmp_pkg::REQ_PAYLOAD) begin
				st = pwmp_pkg::ST_SHORT;
			end else begin
				idx = pw_fa;
				beg = pw_fb;
				len = pw_fc;
				if (idx >= bnd)
					st = pwmp_pkg::ST_RANGE;
			end
		end
		pwmp_pkg::ID_PIECE, pwmp_pkg::ID_CANCEL: ; // consumed, reported with no fields
		default: kind = pwmp_pkg::KIND_UNKNOWN;
		endcase
		res = result_of(kind, st, pw_choking, pw_interested, idx, beg, len);
		pw_phase = PS_LEN;
		pw_count = '0;
	endtask

	// Advance the shadow parser by one accepted byte.
	task automatic parse_byte(input logic [7:0] b, output bit fired, output msg_result_t res);
		logic [31:0] p;
		logic [31:0] cap;
		fired = 1'b0;
		res = '0;
		case (pw_phase)
		PS_ID: begin
			pw_id = b;
			pw_fa = '0;
			pw_fb = '0;
			pw_fc = '0;
			pw_ovf = 1'b0;
			pw_count = 32'd1;
			if (pw_len == 32'd1) begin
				close_msg(res);
				fired = 1'b1;
			end else begin
				pw_phase = PS_BODY;
			end
		end
		PS_BODY: begin
			p = pw_count - 32'd1;
			if (pw_id == pwmp_pkg::ID_HAVE || pw_id == pwmp_pkg::ID_REQUEST) begin
				if (p < 32'(pwmp_pkg::FIELD_BYTES))
					pw_fa = {pw_fa[23:0], b};
				else if (p < 32'(2 * pwmp_pkg::FIELD_BYTES))
					pw_fb = {pw_fb[23:0], b};
				else if (p < 32'(3 * pwmp_pkg::FIELD_BYTES))
					pw_fc = {pw_fc[23:0], b};
			end else if (pw_id == pwmp_pkg::ID_BITFIELD) begin
				cap = (piece_limit() + 32'd7) / 32'd8;
				if (!(p < cap && p < 32'(pwmp_pkg::BITMAP_BYTES)))
					pw_ovf = 1'b1;
			end
			pw_count = pw_count + 32'd1;
			if (pw_count == pw_len) begin
				close_msg(res);
				fired = 1'b1;
			end
		end
		default: begin
			// length prefix, big endian
			pw_len = {pw_len[23:0], b};
			pw_count = pw_count + 32'd1;
			if (pw_count >= 32'd4) begin
				pw_count = '0;
				if (pw_len == '0) begin
					res = result_of(pwmp_pkg::KIND_KEEPALIVE, pwmp_pkg::ST_OK, pw_choking,
						pw_interested, '0, '0, '0);
					fired = 1'b1;
				end else begin
					pw_phase = PS_ID;
				end
			end
		end
		endcase
	endtask

	// Offer one byte, with random idle cycles ahead of it. Entered and left
	// at a falling edge; valid stays up on return so back-to-back bytes
	// keep the channel busy.
	task automatic send_byte(input logic [7:0] b);
		msg_result_t r;
		bit          fired;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		parse_byte(b, fired, r);
		if (fired) begin
			// directed rows with a hand-written result take precedence
			if (typed_pending) begin
				r = typed_want;
				typed_pending = 1'b0;
			end
			owed_q = {owed_q, r};
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	// Length prefix, id, then whatever sits in body_q.
	task automatic send_msg(input bit keepalive, input logic [7:0] id);
		logic [31:0] mlen;
		int          k;
		mlen = keepalive ? 32'd0 : 32'(body_q.size()) + 32'd1;
		for (k = 3; k >= 0; k--)
			send_byte(mlen[8*k +: 8]);
		if (!keepalive) begin
			send_byte(id);
			while (body_q.size() > 0)
				send_byte(body_q.pop_front());
		end
	endtask

	task automatic body_word(input logic [31:0] w);
		body_q = {body_q, w[31:24], w[23:16], w[15:8], w[7:0]};
	endtask

	task automatic body_random(input int unsigned n);
		repeat (n)
			body_q = {body_q, 8'($urandom_range(255))};
	endtask

	// Index mix: around the bound, inside it, and anywhere in 32 bits.
	function automatic logic [31:0] pick_index(input logic [31:0] bnd);
		case ($urandom_range(3))
		0:       return $urandom;
		1:       return bnd;
		2:       return (bnd == '0) ? 32'd0 : bnd - 32'd1;
		default: return $urandom_range(bnd);
		endcase
	endfunction

	// Mostly well-formed messages with random content; about a fifth are
	// broken: random ids with random (often short or padded) payloads.
	task automatic send_random_msg();
		int unsigned pick;
		int unsigned n;
		logic [7:0]  id;
		logic [31:0] bnd;
		logic [31:0] cap;
		bnd = piece_limit();
		cap = (bnd + 32'd7) / 32'd8;
		pick = $urandom_range(99);
		body_q.delete();
		id = '0;
		if (pick < 10) begin
			send_msg(1'b1, id);
		end else if (pick < 80) begin
			id = 8'($urandom_range(8));
			case (id)
			pwmp_pkg::ID_HAVE: body_word(pick_index(bnd));
			pwmp_pkg::ID_REQUEST, pwmp_pkg::ID_CANCEL: begin
				body_word(pick_index(bnd));
				body_word($urandom);
				body_word($urandom);
			end
			pwmp_pkg::ID_BITFIELD: begin
				n = (cap + 2 > 12) ? 12 : cap + 2;
				body_random($urandom_range(n));
			end
			pwmp_pkg::ID_PIECE: body_random(8 + $urandom_range(8));
			default: begin
				// flag messages, now and then with trailing junk
				if ($urandom_range(7) == 0)
					body_random(1 + $urandom_range(2));
			end
			endcase
			send_msg(1'b0, id);
		end else begin
			id = $urandom_range(1) ? 8'($urandom_range(10)) : 8'($urandom_range(255));
			body_random($urandom_range(15));
			send_msg(1'b0, id);
		end
	endtask

	// num_pieces only changes with nothing in flight.
	task automatic write_num_pieces(input logic [15:0] v);
		in_valid = 1'b0;
		while (owed_q.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		pw_num_pieces = v;
	endtask

	function automatic logic [15:0] phase_num_pieces(input int ph);
		case (ph)
		0:       return pwmp_pkg::NUM_PIECES_RST;
		1:       return 16'd0;
		2:       return 16'd9;
		3:       return 16'd1;
		4:       return 16'hFFFF;
		default: return 16'($urandom_range(32768));
		endcase
	endfunction

	task automatic add_msg(input logic [31:0] mlen, input logic [7:0] id,
			input logic [127:0] pay);
		script_row_t row;
		row = '0;
		row.mlen = mlen;
		row.id = id;
		row.pay = pay;
		script = {script, row};
	endtask

	task automatic add_checked(input logic [31:0] mlen, input logic [7:0] id,
			input logic [127:0] pay, input msg_result_t want);
		script_row_t row;
		row = '0;
		row.mlen = mlen;
		row.id = id;
		row.pay = pay;
		row.typed = 1'b1;
		row.want = want;
		script = {script, row};
	endtask

	task automatic add_cfg_write(input logic [15:0] v);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_val = v;
		script = {script, row};
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	// Scoreboard: each output transaction against the oldest owed result.
	always @(posedge clk) begin : result_check
		msg_result_t got;
		msg_result_t exp;
		if (arst_n && out_valid && out_ready) begin
			got = result_of(msg_kind, status, peer_choking_now, peer_interested_now,
				piece_idx, block_begin, block_length);
			if (owed_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("%0t: unexpected result kind=%0d status=%0d idx=%h",
						$realtime, got.kind, got.stat, got.idx);
			end else begin
				exp = owed_q.pop_front();
				if (got.kind !== exp.kind || got.stat !== exp.stat
						|| got.choking !== exp.choking || got.interested !== exp.interested
						|| got.idx !== exp.idx || got.beg !== exp.beg || got.len !== exp.len) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("%0t: mismatch exp kind=%0d st=%0d ch=%b int=%b idx=%h beg=%h len=%h",
							$realtime, exp.kind, exp.stat, exp.choking, exp.interested,
							exp.idx, exp.beg, exp.len);
						$display("%0t:          got kind=%0d st=%0d ch=%b int=%b idx=%h beg=%h len=%h",
							$realtime, got.kind, got.stat, got.choking, got.interested,
							got.idx, got.beg, got.len);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		script_row_t row;
		int          ph;
		int unsigned start;
		int unsigned k;

		// --- directed script (num_pieces at its reset value of 32768) ---
		// keep-alive straight out of reset: peer still choking, not interested
		add_checked(0, 8'd0, '0,
			result_of(pwmp_pkg::KIND_KEEPALIVE, pwmp_pkg::ST_OK, 1'b1, 1'b0, '0, '0, '0));
		add_checked(1, pwmp_pkg::ID_UNCHOKE, '0,
			result_of(pwmp_pkg::KIND_UNCHOKE, pwmp_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0));
		// interested with two junk bytes behind it
		add_checked(3, pwmp_pkg::ID_INTERESTED, {16'hFF00, 112'd0},
			result_of(pwmp_pkg::KIND_INTERESTED, pwmp_pkg::ST_OK, 1'b0, 1'b1, '0, '0, '0));
		// have at both ends of the range, just past it, and at all-ones
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd0, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_OK, 1'b0, 1'b1, 32'd0, '0, '0));
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd32767, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_OK, 1'b0, 1'b1, 32'd32767, '0, '0));
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd32768, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_RANGE, 1'b0, 1'b1, 32'd32768,
				'0, '0));
		add_checked(5, pwmp_pkg::ID_HAVE, {32'hFFFF_FFFF, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_RANGE, 1'b0, 1'b1, 32'hFFFF_FFFF,
				'0, '0));
		// have one byte short: no index reported
		add_checked(4, pwmp_pkg::ID_HAVE, {24'hABCDEF, 104'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_SHORT, 1'b0, 1'b1, '0, '0, '0));
		add_msg(13, pwmp_pkg::ID_REQUEST, {32'd5, 32'hFFFF_FFFF, 32'h0000_4000, 32'd0});
		// out-of-range request still carries all three fields
		add_checked(13, pwmp_pkg::ID_REQUEST, {32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0},
			result_of(pwmp_pkg::KIND_REQUEST, pwmp_pkg::ST_RANGE, 1'b0, 1'b1, 32'h8000_0000,
				32'd0, 32'hFFFF_FFFF));
		add_checked(12, pwmp_pkg::ID_REQUEST, {32'd1, 32'd2, 24'h000003, 40'd0},
			result_of(pwmp_pkg::KIND_REQUEST, pwmp_pkg::ST_SHORT, 1'b0, 1'b1, '0, '0, '0));
		// request padded to 16 payload bytes
		add_msg(17, pwmp_pkg::ID_REQUEST,
			{32'd7, 32'h55AA_55AA, 32'h0001_0000, 32'hDEAD_BEEF});
		add_msg(5, pwmp_pkg::ID_BITFIELD, {32'hF0F0_0F0F, 96'd0});
		add_msg(10, pwmp_pkg::ID_PIECE, {32'd3, 32'h0000_0100, 8'h7E, 56'd0});
		add_msg(13, pwmp_pkg::ID_CANCEL, {32'd3, 32'h0000_0100, 32'h0000_4000, 32'd0});
		add_checked(1, 8'd9, '0,
			result_of(pwmp_pkg::KIND_UNKNOWN, pwmp_pkg::ST_OK, 1'b0, 1'b1, '0, '0, '0));
		add_checked(5, 8'hFF, {32'h0123_4567, 96'd0},
			result_of(pwmp_pkg::KIND_UNKNOWN, pwmp_pkg::ST_OK, 1'b0, 1'b1, '0, '0, '0));
		add_checked(1, pwmp_pkg::ID_NOT_INT, '0,
			result_of(pwmp_pkg::KIND_NOT_INT, pwmp_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0));
		add_checked(1, pwmp_pkg::ID_CHOKE, '0,
			result_of(pwmp_pkg::KIND_CHOKE, pwmp_pkg::ST_OK, 1'b1, 1'b0, '0, '0, '0));
		// 9 pieces: bitmap is two bytes wide, a third byte overflows
		add_cfg_write(16'd9);
		add_checked(4, pwmp_pkg::ID_BITFIELD, {24'hFFFFFF, 104'd0},
			result_of(pwmp_pkg::KIND_BITFIELD, pwmp_pkg::ST_OVERFLOW, 1'b1, 1'b0,
				'0, '0, '0));
		add_msg(3, pwmp_pkg::ID_BITFIELD, {16'h8040, 112'd0});
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd8, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_OK, 1'b1, 1'b0, 32'd8, '0, '0));
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd9, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_RANGE, 1'b1, 1'b0, 32'd9, '0, '0));
		// zero pieces: empty bitfield is fine, any byte overflows, any index is out
		add_cfg_write(16'd0);
		add_msg(1, pwmp_pkg::ID_BITFIELD, '0);
		add_checked(2, pwmp_pkg::ID_BITFIELD, {8'h00, 120'd0},
			result_of(pwmp_pkg::KIND_BITFIELD, pwmp_pkg::ST_OVERFLOW, 1'b1, 1'b0,
				'0, '0, '0));
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd0, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_RANGE, 1'b1, 1'b0, 32'd0, '0, '0));
		// register above the bitmap size is clamped to MAX_PIECES
		add_cfg_write(16'hFFFF);
		add_checked(5, pwmp_pkg::ID_HAVE, {32'd32768, 96'd0},
			result_of(pwmp_pkg::KIND_HAVE, pwmp_pkg::ST_RANGE, 1'b1, 1'b0, 32'd32768,
				'0, '0));
		add_msg(5, pwmp_pkg::ID_HAVE, {32'd32767, 96'd0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the DUT clears its bitmap after reset; send_byte simply waits on in_ready
		foreach (script[i]) begin
			row = script[i];
			if (row.is_cfg) begin
				write_num_pieces(row.cfg_val);
			end else begin
				body_q.delete();
				if (row.mlen != '0)
					for (k = 0; k < row.mlen - 1 && k < 16; k++)
						body_q = {body_q, row.pay[127 - 8*k -: 8]};
				typed_pending = row.typed;
				typed_want = row.want;
				send_msg(row.mlen == '0, row.id);
			end
		end

		// --- random phases: pacing moves from sender-light to receiver-light
		// to no idling at all, with a new num_pieces each phase ---
		for (ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 78 : 0;
			rx_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 18 : 0;
			write_num_pieces(phase_num_pieces(ph));
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				send_random_msg();
		end

		in_valid = 1'b0;
		while (owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
